>>> hdl/assert_macros.svh
// assertion macros used by sine_table_vertex_wave_deform
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define STVWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define STVWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/stvwd_pkg.sv
// types and fixed constants of the vertex wave deform block
package stvwd_pkg;

   localparam int COORD_W     = 24;
   localparam int TEX_W       = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int SINE_W      = 16;
   localparam int UV_SUM_W    = 17;
   localparam int TENT_W      = 17;
   localparam int W_W         = 33;
   localparam int PROD_W      = SINE_W + W_W + 1;
   localparam int DELTA_W     = 14;
   localparam int WAVE_SHIFT  = 5;
   localparam int SWAY_SHIFT  = 34;

   // phase slopes for a 256-entry table
   localparam logic [63:0] C_UV_BASE   = 64'd26701769;
   localparam logic [63:0] C_T_BASE    = 64'd349985421;
   localparam logic [63:0] C_X_BASE    = 64'd87496355;
   localparam logic [63:0] C_Z_BASE    = 64'd58330904;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = coord_type'(24'h7F_FFFF);
   localparam coord_type COORD_MIN = coord_type'(24'h80_0000);

   localparam logic signed [PROD_W-1:0] SWAY_RND = PROD_W'(64'd1 << (SWAY_SHIFT - 1));
   localparam logic signed [SINE_W:0] WAVE_RND = (SINE_W + 1)'(16);

   typedef enum logic [1:0] {
      STYLE_NONE = 2'd0,
      STYLE_X    = 2'd1,
      STYLE_Y    = 2'd2,
      STYLE_Z    = 2'd3
   } style_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEFORM_STYLE = 1'b0,
      REG_FRAME_TIME   = 1'b1
   } csr_reg_type;

   typedef struct packed {
      coord_type              base_x;
      coord_type              base_y;
      coord_type              base_z;
      logic [TEX_W-1:0]       tex_u;
      logic [TEX_W-1:0]       tex_v;
      logic                   last_in;
   } req_payload_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      last_out;
   } rsp_payload_type;

   // loads of the two registers inside the table-size reduction
   typedef struct packed {
      logic load_quot;
      logic load_index;
   } mod_ctl_type;

endpackage

>>> hdl/stvwd_if.sv
// valid/ready channels for vertex beats and displaced vertex beats
interface stvwd_req_if
   import stvwd_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface stvwd_rsp_if
   import stvwd_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/stvwd_phase_mod.sv
// two-stage reduction of a phase value modulo the sine table size
module stvwd_phase_mod
   import stvwd_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int Q_WIDTH = 32
) (
   input  logic                        clock,
   input  mod_ctl_type                 ctl,
   input  logic [Q_WIDTH-1:0]          phase,
   output logic [$clog2(ENTRIES)-1:0]  index
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int REM_W = IDX_W + 1;
   localparam logic [63:0] RECIP = (64'd1 << Q_WIDTH) / ENTRIES;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PRD_W = Q_WIDTH + RECIP_W;
   localparam logic [REM_W-1:0] ENTRIES_R = REM_W'(ENTRIES);

   logic [PRD_W-1:0]     prod;
   logic [RECIP_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]     low_ff, low_in;
   logic [2*REM_W-1:0]   back;
   logic [REM_W-1:0]     rem;
   logic [IDX_W-1:0]     index_ff, index_in;

   // quotient estimate is low by at most one, so the remainder stays below 2*ENTRIES
   always_comb begin
      prod     = PRD_W'(phase) * PRD_W'(RECIP[RECIP_W-1:0]);
      quot_in  = prod[Q_WIDTH +: RECIP_W];
      low_in   = phase[REM_W-1:0];
      back     = (2*REM_W)'(quot_ff[REM_W-1:0]) * (2*REM_W)'(ENTRIES_R);
      rem      = low_ff - back[REM_W-1:0];
      index_in = (rem >= ENTRIES_R) ? IDX_W'(rem - ENTRIES_R) : rem[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_quot) begin
         quot_ff <= quot_in;
         low_ff  <= low_in;
      end
      if (ctl.load_index) begin
         index_ff <= index_in;
      end
   end

   assign index = index_ff;

endmodule

>>> hdl/sine_table_vertex_wave_deform.sv
// Sine-table wave displacement of mesh vertices.
// Vertex beats enter on req_bus (valid/ready) and displaced vertex beats
// leave on rsp_bus in the same order, one result per vertex; last_in comes
// back as last_out. The register port (csr_write_en, csr_index, csr_wdata)
// sets the deform style (index 0) and the frame time in ms (index 1); write
// it between batches, with no vertex in flight.
// Throughput is one vertex per clock while rsp_bus is not stalled. There are
// seven register stages from the accepted input beat to rsp valid: texture sum and
// tent weights, the phase and weight multiplies, the wide phase add, the two
// steps of the reduction modulo the table size, the table read with sway
// rounding, and the saturating add. The time-only sway phases run in a
// separate 4-stage path from the frame time register.
// Synchronous reset clears the style and frame time to 0 and empties the
// pipeline; req_bus.ready is low while reset is high. When rsp_bus stalls,
// the pipeline keeps accepting until every stage is full, then drops ready;
// no beat is lost or repeated.
`include "assert_macros.svh"

module sine_table_vertex_wave_deform
   import stvwd_pkg::*;
#(
   parameter int SINE_ENTRIES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   stvwd_req_if.sink               req_bus,
   stvwd_rsp_if.source             rsp_bus,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(SINE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SINE_ENTRIES - 1);
   localparam int QUARTER = SINE_ENTRIES / 4;
   localparam logic [63:0] ROM_DIV = 64'(SINE_ENTRIES - 1);

   localparam logic [63:0] C_UV = (C_UV_BASE * SINE_ENTRIES + 64'd128) / 64'd256;
   localparam logic [63:0] C_T  = (C_T_BASE * SINE_ENTRIES + 64'd128) / 64'd256;
   localparam logic [63:0] C_X  = (C_X_BASE * SINE_ENTRIES + 64'd128) / 64'd256;
   localparam logic [63:0] C_Z  = (C_Z_BASE * SINE_ENTRIES + 64'd128) / 64'd256;

   localparam int UV_CW  = $clog2(C_UV + 64'd1);
   localparam int T_CW   = $clog2(C_T + 64'd1);
   localparam int X_CW   = $clog2(C_X + 64'd1);
   localparam int Z_CW   = $clog2(C_Z + 64'd1);
   localparam int UV_PW  = UV_SUM_W + UV_CW;
   localparam int TCT_W  = CSR_DATA_W + T_CW;
   localparam int TX_W   = CSR_DATA_W + X_CW;
   localparam int TZ_W   = CSR_DATA_W + Z_CW;
   localparam int SUM_W  = ((UV_PW > TCT_W) ? UV_PW : TCT_W) + 1;
   localparam int PH_W   = SUM_W - 32;

   typedef logic signed [SINE_W-1:0] rom_type [SINE_ENTRIES];

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } crd_type;

   // sine of a Q0.32 turn: fold to the first quadrant, Taylor terms to x^11 at Q30
   function automatic logic signed [SINE_W-1:0] sine_of_turn(input logic [31:0] turn);
      logic [1:0]         quad;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      quad = turn[31:30];
      r    = {34'd0, turn[29:0]};
      if (quad[0]) begin
         r = 64'h4000_0000 - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      mag = ($unsigned(sum) + 64'd32768) >> 16;
      return quad[1] ? -$signed(mag[SINE_W-1:0]) : $signed(mag[SINE_W-1:0]);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] turn;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         turn   = (64'(i) << 32) / ROM_DIV;
         rom[i] = sine_of_turn(turn[31:0]);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // tent weight in Q1.16: peak 1.0 at the middle of the texture
   function automatic logic [TENT_W-1:0] tent_weight(input logic [TEX_W-1:0] coord);
      logic [TEX_W:0] span;
      span = coord[TEX_W-1] ? ((TEX_W+1)'(1 << TEX_W) - {1'b0, coord}) : {1'b0, coord};
      return {span[TEX_W-1:0], 1'b0};
   endfunction

   function automatic coord_type sat_add(input coord_type base,
                                         input logic signed [DELTA_W-1:0] delta);
      logic signed [COORD_W:0] sum;
      sum = {base[COORD_W-1], base} + {{(COORD_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
      if (sum[COORD_W] != sum[COORD_W-1]) begin
         return sum[COORD_W] ? COORD_MIN : COORD_MAX;
      end
      return sum[COORD_W-1:0];
   endfunction

   // configuration
   style_type               style_ff, style_in;
   logic [CSR_DATA_W-1:0]   frame_time_ff, frame_time_in;

   // time path runs free; user holds frame time with beats in flight, not enforced
   logic [TCT_W-1:0]        tct_ff, tct_in;
   logic [TX_W-1:0]         tx_prod;
   logic [TZ_W-1:0]         tz_prod;
   logic [PH_W-1:0]         qx_ff, qx_in;
   logic [PH_W-1:0]         qz_ff, qz_in;
   logic [IDX_W-1:0]        ix, iz;
   logic signed [SINE_W-1:0] sx_ff, sz_ff;
   mod_ctl_type             time_ctl;

   // beat pipeline control
   logic [7:1]              vld_ff, vld_in;
   logic [7:1]              stage_en;
   mod_ctl_type             item_ctl;

   // beat pipeline data
   crd_type                 crd_ff [1:6];
   crd_type                 crd_in;
   logic [UV_SUM_W-1:0]     uvsum1_ff, uvsum1_in;
   logic [TENT_W-1:0]       tu1_ff, tu1_in;
   logic [TENT_W-1:0]       tv1_ff, tv1_in;
   logic [UV_PW-1:0]        uvp2_ff, uvp2_in;
   logic [W_W-1:0]          w2_ff, w2_in;
   logic [SUM_W-1:0]        phase_sum;
   logic [PH_W-1:0]         phase3_ff, phase3_in;
   logic [W_W-1:0]          w3_ff;
   logic [W_W-1:0]          w4_ff;
   logic [IDX_W-1:0]        idx5;
   logic signed [PROD_W-1:0] px5_ff, px5_in;
   logic signed [PROD_W-1:0] pz5_ff, pz5_in;
   logic signed [SINE_W-1:0] rom_s;
   logic signed [SINE_W:0]   wave_sum;
   logic signed [DELTA_W-1:0] wave;
   logic signed [PROD_W-1:0] sway_x_sum;
   logic signed [PROD_W-1:0] sway_z_sum;
   logic signed [DELTA_W-1:0] sway_x;
   logic signed [DELTA_W-1:0] sway_z;
   logic signed [DELTA_W-1:0] dx6_ff, dx6_in;
   logic signed [DELTA_W-1:0] dy6_ff, dy6_in;
   logic signed [DELTA_W-1:0] dz6_ff, dz6_in;
   rsp_payload_type         rsp_ff, rsp_in;

   // register port
   always_comb begin
      style_in      = style_ff;
      frame_time_in = frame_time_ff;
      if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            REG_DEFORM_STYLE: style_in      = style_type'(csr_wdata[1:0]);
            REG_FRAME_TIME:   frame_time_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff      <= STYLE_NONE;
         frame_time_ff <= '0;
      end else begin
         style_ff      <= style_in;
         frame_time_ff <= frame_time_in;
      end
   end

   // time path: slopes, reduction, table read
   always_comb begin
      tct_in  = TCT_W'(frame_time_ff) * TCT_W'(C_T);
      tx_prod = TX_W'(frame_time_ff) * TX_W'(C_X);
      tz_prod = TZ_W'(frame_time_ff) * TZ_W'(C_Z);
      qx_in   = PH_W'(tx_prod[TX_W-1:32]);
      // z sway runs a quarter turn ahead
      qz_in   = PH_W'(tz_prod[TZ_W-1:32]) + PH_W'(QUARTER);
      time_ctl.load_quot  = 1'b1;
      time_ctl.load_index = 1'b1;
   end

   always_ff @(posedge clock) begin
      tct_ff <= tct_in;
      qx_ff  <= qx_in;
      qz_ff  <= qz_in;
      sx_ff  <= SINE_ROM[ix];
      sz_ff  <= SINE_ROM[iz];
   end

   stvwd_phase_mod #(
      .ENTRIES (SINE_ENTRIES),
      .Q_WIDTH (PH_W)
   ) u_mod_x (
      .clock (clock),
      .ctl   (time_ctl),
      .phase (qx_ff),
      .index (ix)
   );

   stvwd_phase_mod #(
      .ENTRIES (SINE_ENTRIES),
      .Q_WIDTH (PH_W)
   ) u_mod_z (
      .clock (clock),
      .ctl   (time_ctl),
      .phase (qz_ff),
      .index (iz)
   );

   // stall chain: a stage loads when it is empty or its successor moves on
   always_comb begin
      stage_en[7] = !vld_ff[7] || rsp_bus.ready;
      for (int k = 6; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in = vld_ff;
      if (stage_en[1]) begin
         vld_in[1] = req_bus.valid;
      end
      for (int k = 2; k <= 7; k++) begin
         if (stage_en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
      item_ctl.load_quot  = stage_en[4];
      item_ctl.load_index = stage_en[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // beat datapath
   always_comb begin
      crd_in.x    = req_bus.payload.base_x;
      crd_in.y    = req_bus.payload.base_y;
      crd_in.z    = req_bus.payload.base_z;
      crd_in.last = req_bus.payload.last_in;
      uvsum1_in   = UV_SUM_W'(req_bus.payload.tex_u) + UV_SUM_W'(req_bus.payload.tex_v);
      tu1_in      = tent_weight(req_bus.payload.tex_u);
      tv1_in      = tent_weight(req_bus.payload.tex_v);

      uvp2_in     = UV_PW'(uvsum1_ff) * UV_PW'(C_UV);
      w2_in       = W_W'(tu1_ff) * W_W'(tv1_ff);

      phase_sum   = SUM_W'(uvp2_ff) + SUM_W'(tct_ff);
      phase3_in   = phase_sum[SUM_W-1:32];

      px5_in      = $signed({{(PROD_W-SINE_W){sx_ff[SINE_W-1]}}, sx_ff})
                    * $signed({{(PROD_W-W_W){1'b0}}, w4_ff});
      pz5_in      = $signed({{(PROD_W-SINE_W){sz_ff[SINE_W-1]}}, sz_ff})
                    * $signed({{(PROD_W-W_W){1'b0}}, w4_ff});

      rom_s       = SINE_ROM[idx5];
      wave_sum    = {rom_s[SINE_W-1], rom_s} + WAVE_RND;
      wave        = DELTA_W'(wave_sum >>> WAVE_SHIFT);
      sway_x_sum  = px5_ff + SWAY_RND;
      sway_z_sum  = pz5_ff + SWAY_RND;
      sway_x      = DELTA_W'(sway_x_sum >>> SWAY_SHIFT);
      sway_z      = DELTA_W'(sway_z_sum >>> SWAY_SHIFT);

      dx6_in = '0;
      dy6_in = '0;
      dz6_in = '0;
      case (style_ff)
         STYLE_NONE: ;
         STYLE_X:    dx6_in = wave;
         STYLE_Y: begin
            dx6_in = sway_x;
            dy6_in = wave;
            dz6_in = sway_z;
         end
         STYLE_Z:    dz6_in = wave;
         default:    ;
      endcase

      rsp_in.out_x    = sat_add(crd_ff[6].x, dx6_ff);
      rsp_in.out_y    = sat_add(crd_ff[6].y, dy6_ff);
      rsp_in.out_z    = sat_add(crd_ff[6].z, dz6_ff);
      rsp_in.last_out = crd_ff[6].last;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         crd_ff[1] <= crd_in;
         uvsum1_ff <= uvsum1_in;
         tu1_ff    <= tu1_in;
         tv1_ff    <= tv1_in;
      end
      for (int k = 2; k <= 6; k++) begin
         if (stage_en[k]) begin
            crd_ff[k] <= crd_ff[k-1];
         end
      end
      if (stage_en[2]) begin
         uvp2_ff <= uvp2_in;
         w2_ff   <= w2_in;
      end
      if (stage_en[3]) begin
         phase3_ff <= phase3_in;
         w3_ff     <= w2_ff;
      end
      if (stage_en[4]) begin
         w4_ff <= w3_ff;
      end
      if (stage_en[5]) begin
         px5_ff <= px5_in;
         pz5_ff <= pz5_in;
      end
      if (stage_en[6]) begin
         dx6_ff <= dx6_in;
         dy6_ff <= dy6_in;
         dz6_ff <= dz6_in;
      end
      if (stage_en[7]) begin
         rsp_ff <= rsp_in;
      end
   end

   stvwd_phase_mod #(
      .ENTRIES (SINE_ENTRIES),
      .Q_WIDTH (PH_W)
   ) u_mod_wave (
      .clock (clock),
      .ctl   (item_ctl),
      .phase (phase3_ff),
      .index (idx5)
   );

   assign req_bus.ready   = stage_en[1] && !reset;
   assign rsp_bus.valid   = vld_ff[7];
   assign rsp_bus.payload = rsp_ff;

   `STVWD_ASSERT_NOW(a_wave_index_range, clock, reset, vld_ff[5], idx5 <= IDX_MAX,
      "wave table index past the last entry")
   `STVWD_ASSERT_NOW(a_ready_only_when_full, clock, reset, !req_bus.ready, &vld_ff,
      "input stalled with a free stage")
   `STVWD_ASSERT_NEXT(a_beat_enters, clock, reset, req_bus.valid && req_bus.ready,
      vld_ff[1], "accepted beat missing from first stage")
   `STVWD_ASSERT_NOW(a_pass_through_zero, clock, reset, vld_ff[6] && style_ff == STYLE_NONE,
      dx6_ff == '0 && dy6_ff == '0 && dz6_ff == '0, "nonzero displacement with no deform style")

endmodule
